// File: hw/rtl/cakt_pkg.sv
package cakt_pkg;

    // stream widths
    localparam int IN_W   = 168;
    localparam int OUT_W  = 56;
    localparam int CFG_W  = 4;

    // storage widths
    localparam int DIR_W  = 64;
    localparam int RAW_W  = 32;
    localparam int MU_W   = 17;
    localparam int RAWE_W = RAW_W + MU_W;

    // 2 * 511000 eV in Q.15
    localparam logic [34:0] MEC2_Q15 = 35'd33488896000;

    // divider step counts
    localparam logic [5:0] Q_STEPS = 6'd29;
    localparam logic [5:0] S_STEPS = 6'd32;

    typedef enum logic [21:0] {
        ST_IDLE  = 22'h000001,
        ST_RD_A  = 22'h000002,
        ST_RD_B  = 22'h000004,
        ST_CAP_B = 22'h000008,
        ST_DOT0  = 22'h000010,
        ST_DOT1  = 22'h000020,
        ST_DOT2  = 22'h000040,
        ST_MU    = 22'h000080,
        ST_PROD  = 22'h000100,
        ST_DEN   = 22'h000200,
        ST_QGO   = 22'h000400,
        ST_QDIV  = 22'h000800,
        ST_SQR   = 22'h001000,
        ST_RAW   = 22'h002000,
        ST_TERM  = 22'h004000,
        ST_ACC   = 22'h008000,
        ST_SRD   = 22'h010000,
        ST_SMUL  = 22'h020000,
        ST_SGO   = 22'h040000,
        ST_SDIV  = 22'h080000,
        ST_EMIT  = 22'h100000,
        ST_SPARE = 22'h200000
    } state_t;

    typedef enum logic [1:0] {
        DOT_MU  = 2'd0,
        DOT_ETA = 2'd1,
        DOT_XI  = 2'd2
    } dot_sel_t;

    // controller to datapath
    typedef struct packed {
        logic       dir_we;
        logic       cap_in;
        logic       dir_re;
        logic [2:0] dir_addr;
        logic       cap_a;
        logic       cap_b;
        logic       dot_first;
        dot_sel_t   dot_sel;
        logic       mu_en;
        logic       prod_en;
        logic       den_en;
        logic       qgo;
        logic       div_step;
        logic       sqr_en;
        logic       raw_en;
        logic       term_en;
        logic       k_clr;
        logic       k_acc;
        logic       raw_re;
        logic [5:0] raw_addr;
        logic       smul_en;
        logic       sgo;
        logic       emit;
        logic [2:0] a;
        logic [2:0] b;
        logic       last;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_load;
        logic load_ok;
        logic down_ok;
        logic div_done;
        logic out_free;
    } sts_t;

endpackage

// File: hw/rtl/compton_angular_kernel_table.sv
// load word: input stays ready; upscatter pair: input stays ready, no output words
// pair with n active angles: a first pass forms n^2 raw values and their weighted sum, a second
// pass scales each raw value into one output word, both through the shared one-bit-per-cycle divider
// (a reciprocal per value in the first pass, a scaling per value in the second)
// one item at a time; the last output word may wait while the next is taken
// aresetn is synchronous, active low; angle_count resets to MAX_ANGLES
module compton_angular_kernel_table import cakt_pkg::*; #(
    parameter int MAX_ANGLES = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    // angle_index, dir_mu, dir_eta, dir_xi, angle_weight, energy_low_ev,
    // energy_high_ev, pair_sigma, source_group, sink_group, pad
    input  logic [IN_W-1:0]  s_tdata,
    input  logic             s_tuser,   // op
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // kernel_value, src_angle, sink_angle, cosine_out, pad
    output logic             m_tuser,   // status
    output logic             m_tlast,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data
);

    cmd_t cmd;
    sts_t sts;

    // sequencer
    cakt_ctrl #(.MAX_ANGLES(MAX_ANGLES)) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .sts       (sts),
        .cmd       (cmd)
    );

    // arithmetic and storage
    cakt_dp #(.MAX_ANGLES(MAX_ANGLES)) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// File: hw/rtl/cakt_ram.sv
module cakt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hw/rtl/cakt_ctrl.sv
module cakt_ctrl import cakt_pkg::*; #(
    parameter int MAX_ANGLES = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data,
    input  sts_t             sts,
    output cmd_t             cmd
);

    state_t     state_reg, state_next;
    logic [3:0] count_reg;
    logic [2:0] a_reg, a_next;
    logic [2:0] b_reg, b_next;
    logic [5:0] idx_reg, idx_next;
    logic [3:0] n_act;
    logic       last_a, last_b;

    // active angle count, clamped to 1..MAX_ANGLES
    always_comb begin
        if (count_reg == 4'd0) begin
            n_act = 4'd1;
        end else if (count_reg > 4'(MAX_ANGLES)) begin
            n_act = 4'(MAX_ANGLES);
        end else begin
            n_act = count_reg;
        end
    end

    assign last_a    = ({1'b0, a_reg} == n_act - 4'd1);
    assign last_b    = ({1'b0, b_reg} == n_act - 4'd1);
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    // sequencer
    always_comb begin
        state_next   = state_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        idx_next     = idx_reg;
        cmd          = '0;
        cmd.dir_addr = a_reg;
        cmd.raw_addr = idx_reg;
        cmd.a        = a_reg;
        cmd.b        = b_reg;
        cmd.last     = last_a && last_b;
        cmd.dot_sel  = DOT_MU;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (sts.is_load) begin
                        cmd.dir_we = sts.load_ok;
                    end else if (sts.down_ok) begin
                        cmd.cap_in = 1'b1;
                        cmd.k_clr  = 1'b1;
                        a_next     = 3'd0;
                        b_next     = 3'd0;
                        idx_next   = 6'd0;
                        state_next = ST_RD_A;
                    end
                end
            end
            ST_RD_A: begin
                cmd.dir_re = 1'b1;
                state_next = ST_RD_B;
            end
            ST_RD_B: begin
                cmd.cap_a    = 1'b1;
                cmd.dir_re   = 1'b1;
                cmd.dir_addr = b_reg;
                state_next   = ST_CAP_B;
            end
            ST_CAP_B: begin
                cmd.cap_b  = 1'b1;
                state_next = ST_DOT0;
            end
            ST_DOT0: begin
                cmd.dot_first = 1'b1;
                cmd.dot_sel   = DOT_MU;
                state_next    = ST_DOT1;
            end
            ST_DOT1: begin
                cmd.dot_sel = DOT_ETA;
                state_next  = ST_DOT2;
            end
            ST_DOT2: begin
                cmd.dot_sel = DOT_XI;
                state_next  = ST_MU;
            end
            ST_MU: begin
                cmd.mu_en  = 1'b1;
                state_next = ST_PROD;
            end
            ST_PROD: begin
                cmd.prod_en = 1'b1;
                state_next  = ST_DEN;
            end
            ST_DEN: begin
                cmd.den_en = 1'b1;
                state_next = ST_QGO;
            end
            ST_QGO: begin
                cmd.qgo    = 1'b1;
                state_next = ST_QDIV;
            end
            ST_QDIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_done) begin
                    state_next = ST_SQR;
                end
            end
            ST_SQR: begin
                cmd.sqr_en = 1'b1;
                state_next = ST_RAW;
            end
            ST_RAW: begin
                cmd.raw_en = 1'b1;
                state_next = ST_TERM;
            end
            ST_TERM: begin
                cmd.term_en = 1'b1;
                state_next  = ST_ACC;
            end
            ST_ACC: begin
                cmd.k_acc = 1'b1;
                idx_next  = idx_reg + 6'd1;
                if (last_b) begin
                    b_next = 3'd0;
                    if (last_a) begin
                        a_next     = 3'd0;
                        idx_next   = 6'd0;
                        state_next = ST_SRD;
                    end else begin
                        a_next     = a_reg + 3'd1;
                        state_next = ST_RD_A;
                    end
                end else begin
                    b_next     = b_reg + 3'd1;
                    state_next = ST_RD_A;
                end
            end
            ST_SRD: begin
                cmd.raw_re = 1'b1;
                state_next = ST_SMUL;
            end
            ST_SMUL: begin
                cmd.smul_en = 1'b1;
                state_next  = ST_SGO;
            end
            ST_SGO: begin
                cmd.sgo    = 1'b1;
                state_next = ST_SDIV;
            end
            ST_SDIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    idx_next = idx_reg + 6'd1;
                    if (last_b) begin
                        b_next = 3'd0;
                        if (last_a) begin
                            a_next     = 3'd0;
                            state_next = ST_IDLE;
                        end else begin
                            a_next     = a_reg + 3'd1;
                            state_next = ST_SRD;
                        end
                    end else begin
                        b_next     = b_reg + 3'd1;
                        state_next = ST_SRD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and angle counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            a_reg     <= 3'd0;
            b_reg     <= 3'd0;
            idx_reg   <= 6'd0;
            count_reg <= 4'(MAX_ANGLES);
        end else begin
            state_reg <= state_next;
            a_reg     <= a_next;
            b_reg     <= b_next;
            idx_reg   <= idx_next;
            if (cfg_valid) begin
                count_reg <= cfg_data;
            end
        end
    end

endmodule

// File: hw/rtl/cakt_dp.sv
module cakt_dp import cakt_pkg::*; #(
    parameter int MAX_ANGLES = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [IN_W-1:0]  s_tdata,
    input  logic             s_tuser,
    input  cmd_t             cmd,
    output sts_t             sts,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // kernel_value, src_angle, sink_angle, cosine_out, pad
    output logic             m_tuser,   // status
    output logic             m_tlast
);

    localparam int DEPTH_R = MAX_ANGLES * MAX_ANGLES;
    localparam int AW_D    = MAX_ANGLES > 1 ? $clog2(MAX_ANGLES) : 1;
    localparam int AW_R    = DEPTH_R > 1 ? $clog2(DEPTH_R) : 1;

    // input word fields
    logic [2:0]  idx_in;
    logic [24:0] elow_in, ehigh_in;
    logic [31:0] sigma_in;
    logic [7:0]  src_in, sink_in;

    assign idx_in   = s_tdata[2:0];
    assign elow_in  = s_tdata[91:67];
    assign ehigh_in = s_tdata[116:92];
    assign sigma_in = s_tdata[148:117];
    assign src_in   = s_tdata[156:149];
    assign sink_in  = s_tdata[164:157];

    logic [DIR_W-1:0]  dir_rd;
    logic [RAWE_W-1:0] raw_rd;

    logic [25:0]            s_sum_reg;
    logic [31:0]            sigma_reg;
    logic [DIR_W-1:0]       a_dir_reg, b_dir_reg;
    logic signed [33:0]     acc_reg;
    logic signed [MU_W-1:0] mu_reg;
    logic [31:0]            ww_reg;
    logic [42:0]            st_reg;
    logic [43:0]            den_reg;
    logic [30:0]            m2_reg;
    logic [28:0]            q_reg, q2_reg;
    logic [RAW_W-1:0]       raw_reg;
    logic [63:0]            tp_reg;
    logic [47:0]            k_reg;
    logic [63:0]            p_reg;
    logic [MU_W-1:0]        muo_reg;
    logic                   sat_reg;
    logic [49:0]            rem_reg;
    logic [31:0]            quo_reg, lo_reg;
    logic [48:0]            dvs_reg;
    logic [5:0]             cnt_reg;
    logic                   out_valid_reg;
    logic [OUT_W-1:0]       out_data_reg;
    logic                   out_user_reg, out_last_reg;

    // direction table and raw value store
    cakt_ram #(.WIDTH(DIR_W), .DEPTH(MAX_ANGLES)) u_dir_ram (
        .aclk  (aclk),
        .we    (cmd.dir_we),
        .waddr (idx_in[AW_D-1:0]),
        .wdata (s_tdata[66:3]),
        .re    (cmd.dir_re),
        .raddr (cmd.dir_addr[AW_D-1:0]),
        .rdata (dir_rd)
    );

    cakt_ram #(.WIDTH(RAWE_W), .DEPTH(DEPTH_R)) u_raw_ram (
        .aclk  (aclk),
        .we    (cmd.term_en),
        .waddr (cmd.raw_addr[AW_R-1:0]),
        .wdata ({mu_reg, raw_reg}),
        .re    (cmd.raw_re),
        .raddr (cmd.raw_addr[AW_R-1:0]),
        .rdata (raw_rd)
    );

    // status
    assign sts.is_load  = !s_tuser;
    assign sts.load_ok  = ({1'b0, idx_in} < 4'(MAX_ANGLES));
    assign sts.down_ok  = (sink_in >= src_in);
    assign sts.div_done = (cnt_reg == 6'd0);
    assign sts.out_free = !out_valid_reg || m_tready;

    // dot product, one component a cycle
    logic signed [15:0] ca, cb;
    logic signed [31:0] dprod;
    always_comb begin
        case (cmd.dot_sel)
            DOT_MU: begin
                ca = a_dir_reg[15:0];
                cb = b_dir_reg[15:0];
            end
            DOT_ETA: begin
                ca = a_dir_reg[31:16];
                cb = b_dir_reg[31:16];
            end
            default: begin
                ca = a_dir_reg[47:32];
                cb = b_dir_reg[47:32];
            end
        endcase
    end
    assign dprod = ca * cb;

    // mu rounding and saturation
    logic signed [33:0] mu_sh;
    logic signed [MU_W-1:0] mu_sat;
    assign mu_sh = (acc_reg + 34'sd16384) >>> 15;
    always_comb begin
        if (mu_sh < -34'sd65536) begin
            mu_sat = -17'sd65536;
        end else if (mu_sh > 34'sd65535) begin
            mu_sat = 17'sd65535;
        end else begin
            mu_sat = mu_sh[MU_W-1:0];
        end
    end

    // 1 - mu, floored at zero
    logic signed [17:0] t_s;
    logic [16:0]        t_u;
    assign t_s = 18'sd32768 - 18'(mu_reg);
    assign t_u = t_s[17] ? 17'd0 : t_s[16:0];

    logic signed [33:0] msq;
    assign msq = mu_reg * mu_reg;
    logic [33:0] m2_full;
    assign m2_full = msq + 34'sd2;

    logic [63:0] numq;
    assign numq = (64'(MEC2_Q15) << 28) + 64'(den_reg[43:1]);

    logic [57:0] qsq;
    assign qsq = quo_reg[28:0] * quo_reg[28:0] + 58'd134217728;

    logic [30:0] qm_sum;
    logic [59:0] rp;
    assign qm_sum = 31'(q2_reg) + m2_reg;
    assign rp     = q_reg * qm_sum + 60'd67108864;

    // restoring divider step
    logic [49:0] trial;
    logic        ge;
    assign trial = {rem_reg[48:0], lo_reg[31]};
    assign ge    = (trial >= {1'b0, dvs_reg});

    // rounding of the scaled value
    logic        rup;
    logic [32:0] qt;
    logic [31:0] val;
    assign rup = (rem_reg >= {2'b00, k_reg});
    assign qt  = {1'b0, quo_reg} + 33'(rup);
    always_comb begin
        if (k_reg == 48'd0) begin
            val = 32'd0;
        end else if (sat_reg || qt[32]) begin
            val = 32'hFFFF_FFFF;
        end else begin
            val = qt[31:0];
        end
    end

    // arithmetic registers
    always_ff @(posedge aclk) begin
        if (cmd.cap_in) begin
            s_sum_reg <= 26'(elow_in) + 26'(ehigh_in);
            sigma_reg <= sigma_in;
        end
        if (cmd.cap_a) begin
            a_dir_reg <= dir_rd;
        end
        if (cmd.cap_b) begin
            b_dir_reg <= dir_rd;
        end
        if (cmd.dot_first) begin
            acc_reg <= 34'(dprod);
        end else if (cmd.dot_sel != DOT_MU) begin
            acc_reg <= acc_reg + 34'(dprod);
        end
        if (cmd.mu_en) begin
            mu_reg <= mu_sat;
            ww_reg <= a_dir_reg[63:48] * b_dir_reg[63:48];
        end
        if (cmd.prod_en) begin
            st_reg <= s_sum_reg * t_u;
        end
        if (cmd.den_en) begin
            den_reg <= 44'(MEC2_Q15) + 44'(st_reg);
            m2_reg  <= m2_full[32:2];
        end
        if (cmd.sqr_en) begin
            q_reg  <= quo_reg[28:0];
            q2_reg <= qsq[56:28];
        end
        if (cmd.raw_en) begin
            raw_reg <= rp[58:27];
        end
        if (cmd.term_en) begin
            tp_reg <= raw_reg * ww_reg;
        end
        if (cmd.smul_en) begin
            p_reg   <= raw_rd[RAW_W-1:0] * sigma_reg;
            muo_reg <= raw_rd[RAWE_W-1:RAW_W];
        end
        if (cmd.sgo) begin
            sat_reg <= ({17'd0, p_reg[63:32]} >= {k_reg, 1'b0});
        end
    end

    // weighted sum
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg <= 48'd0;
        end else if (cmd.k_clr) begin
            k_reg <= 48'd0;
        end else if (cmd.k_acc) begin
            k_reg <= k_reg + 48'(tp_reg[63:29]);
        end
    end

    // shared divider, one quotient bit a cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 6'd0;
        end else if (cmd.qgo) begin
            rem_reg <= 50'(numq[63:29]);
            lo_reg  <= {numq[28:0], 3'b000};
            dvs_reg <= 49'(den_reg);
            quo_reg <= 32'd0;
            cnt_reg <= Q_STEPS;
        end else if (cmd.sgo) begin
            rem_reg <= 50'(p_reg[63:32]);
            lo_reg  <= p_reg[31:0];
            dvs_reg <= {k_reg, 1'b0};
            quo_reg <= 32'd0;
            cnt_reg <= S_STEPS;
        end else if (cmd.div_step && cnt_reg != 6'd0) begin
            rem_reg <= ge ? trial - {1'b0, dvs_reg} : trial;
            quo_reg <= {quo_reg[30:0], ge};
            lo_reg  <= {lo_reg[30:0], 1'b0};
            cnt_reg <= cnt_reg - 6'd1;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_data_reg <= {1'b0, muo_reg, cmd.b, cmd.a, val};
            out_user_reg <= (k_reg == 48'd0);
            out_last_reg <= cmd.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

endmodule

// File: hw/rtl/cakt_checker.sv
module cakt_checker import cakt_pkg::*; (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic [IN_W-1:0]  s_tdata,
    input logic             s_tuser,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata,
    input logic             m_tuser,
    input logic             m_tlast,
    input logic             cfg_valid,
    input logic             cfg_ready,
    input logic [CFG_W-1:0] cfg_data
);

    // a stalled output word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    // a downscatter pair starts a run and blocks input
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser && (s_tdata[164:157] >= s_tdata[156:149])
        |=> !s_tready)
        else $error("input not blocked after pair accepted");

    // load words and upscatter pairs leave input ready
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (!s_tuser || (s_tdata[164:157] < s_tdata[156:149]))
        |=> s_tready)
        else $error("input blocked after word without results");

    // configuration is always taken
    assert property (@(posedge aclk) disable iff (!aresetn) cfg_ready)
        else $error("configuration port not ready");

endmodule

bind compton_angular_kernel_table cakt_checker u_cakt_checker (.*);

// File: bench/tb_compton_angular_kernel_table.sv
`timescale 1ns / 1ps

module tb_compton_angular_kernel_table import cakt_pkg::*;;

    localparam int  N_ANG        = 8;
    localparam int  RANDOM_WORDS = 185;
    localparam int  SETTLE       = 40;
    localparam longint CYCLE_LIMIT = 10000000;

    typedef enum logic {OP_LOAD = 1'b0, OP_PAIR = 1'b1} op_t;
    typedef enum logic [1:0] {ROW_WORD, ROW_CFG} row_kind_t;

    // one input word, or one angle_count write
    typedef struct {
        row_kind_t   kind;
        op_t         op;
        logic [2:0]  idx;
        logic [15:0] mu, eta, xi, wt;
        logic [24:0] elo, ehi;
        logic [31:0] sigma;
        logic [7:0]  src_grp, snk_grp;
        logic [3:0]  cnt;
        bit          zero_sum;  // typed expectation: every value 0, status 1
    } stim_row_t;

    typedef struct {
        logic [31:0] kernel;
        logic [2:0]  src_ang;
        logic [2:0]  snk_ang;
        logic [16:0] cosine;
        logic        status;
        logic        last;
    } kernel_word_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;
    logic             s_tuser = 1'b0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic             m_tuser;
    logic             m_tlast;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data = '0;

    // predictor state
    logic signed [15:0] dir_cos [N_ANG][3];
    logic [15:0]        dir_wt [N_ANG];
    logic [3:0]         angle_cnt = 4'd8;

    kernel_word_t kernel_expect_q [$];
    stim_row_t    directed_rows [$];
    int           errors = 0;
    longint       cycles = 0;
    bit           no_idle = 1'b0;
    int           words_sent = 0;

    compton_angular_kernel_table u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (no_idle || r < 11) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(15, 70);
    endfunction

    // scattering cosine in Q2.15, rounded and saturated
    function automatic longint cosine_q15(int a, int b);
        longint p, m;
        p = 0;
        for (int k = 0; k < 3; k++)
            p += longint'(dir_cos[a][k]) * longint'(dir_cos[b][k]);
        m = ((p + 64'sd4294967296 + 16384) >>> 15) - 131072;
        if (m < -65536) m = -65536;
        if (m > 65535) m = 65535;
        return m;
    endfunction

    // q * (q^2 + mu^2) in Q3.29
    function automatic logic [63:0] raw_q29(longint mq, logic [63:0] s);
        longint      t;
        logic [63:0] c, d, q, q2, m2;
        c = 64'(MEC2_Q15);
        t = 32768 - mq;
        if (t < 0) t = 0;
        d  = c + s * 64'(t);
        q  = ((c << 28) + d / 2) / d;
        q2 = (q * q + (64'd1 << 27)) >> 28;
        m2 = (64'(mq * mq) + 2) >> 2;
        return (q * (q2 + m2) + (64'd1 << 26)) >> 27;
    endfunction

    // expected words of one pair item
    task automatic kernel_predict(stim_row_t r);
        int           n, i;
        logic [63:0]  s, kk, ksum, p, dv, qt, rm;
        logic [63:0]  raws [N_ANG * N_ANG];
        longint       mus [N_ANG * N_ANG];
        kernel_word_t w;
        if (r.snk_grp < r.src_grp) return;  // upscatter: nothing out
        n = angle_cnt == 0 ? 1 : (angle_cnt > N_ANG ? N_ANG : angle_cnt);
        s = 64'(r.elo) + 64'(r.ehi);
        kk = 0;
        for (int a = 0; a < n; a++)
            for (int b = 0; b < n; b++) begin
                i = a * n + b;
                mus[i]  = cosine_q15(a, b);
                raws[i] = raw_q29(mus[i], s);
                kk += (raws[i] * (64'(dir_wt[a]) * 64'(dir_wt[b]))) >> 29;
            end
        ksum = {16'd0, kk[47:0]};
        for (int a = 0; a < n; a++)
            for (int b = 0; b < n; b++) begin
                i = a * n + b;
                w.kernel = '0;
                w.status = 1'b1;
                if (ksum != 0) begin
                    p  = raws[i] * 64'(r.sigma);
                    dv = 2 * ksum;
                    qt = p / dv;
                    rm = p % dv;
                    if (rm >= ksum) qt++;
                    w.kernel = qt > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : qt[31:0];
                    w.status = 1'b0;
                end
                if (r.zero_sum) begin
                    w.kernel = '0;
                    w.status = 1'b1;
                end
                w.src_ang = 3'(a);
                w.snk_ang = 3'(b);
                w.cosine  = 17'(mus[i]);
                w.last    = (i == n * n - 1);
                kernel_expect_q.push_back(w);
            end
    endtask

    // hand one word to the block, predict on accept
    task automatic send_word(stim_row_t r);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end else begin
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.op;
        s_tdata  <= {3'd0, r.snk_grp, r.src_grp, r.sigma, r.ehi, r.elo,
                     r.wt, r.xi, r.eta, r.mu, r.idx};
        do @(posedge aclk); while (!s_tready);
        words_sent++;
        if (r.op == OP_LOAD) begin
            dir_cos[r.idx][0] = r.mu;
            dir_cos[r.idx][1] = r.eta;
            dir_cos[r.idx][2] = r.xi;
            dir_wt[r.idx]     = r.wt;
        end else begin
            kernel_predict(r);
        end
    endtask

    // angle_count write once the block has drained
    task automatic write_count(logic [3:0] v);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (kernel_expect_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        angle_cnt = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic stim_row_t load_row(logic [2:0] idx, logic [15:0] mu, logic [15:0] eta,
                                           logic [15:0] xi, logic [15:0] wt);
        stim_row_t r;
        r = '{kind: ROW_WORD, op: OP_LOAD, idx: idx, mu: mu, eta: eta, xi: xi, wt: wt,
              elo: '0, ehi: '0, sigma: '0, src_grp: '0, snk_grp: '0, cnt: '0,
              zero_sum: 1'b0};
        return r;
    endfunction

    function automatic stim_row_t pair_row(logic [24:0] elo, logic [24:0] ehi,
                                           logic [31:0] sigma, logic [7:0] sg,
                                           logic [7:0] kg, bit zs);
        stim_row_t r;
        r = load_row(3'd0, '0, '0, '0, '0);
        r.op = OP_PAIR;
        r.elo = elo; r.ehi = ehi; r.sigma = sigma;
        r.src_grp = sg; r.snk_grp = kg; r.zero_sum = zs;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(logic [3:0] v);
        stim_row_t r;
        r = load_row(3'd0, '0, '0, '0, '0);
        r.kind = ROW_CFG;
        r.cnt  = v;
        return r;
    endfunction

    // random load: near unit vectors mostly, raw noise otherwise
    function automatic stim_row_t rand_load();
        logic [15:0] c [3];
        int          hot;
        if ($urandom_range(0, 2) == 0) begin
            for (int k = 0; k < 3; k++) c[k] = 16'($urandom);
        end else begin
            hot = $urandom_range(0, 2);
            for (int k = 0; k < 3; k++)
                c[k] = (k == hot) ? 16'($urandom_range(20000, 32767))
                                  : 16'($urandom_range(0, 18000));
            for (int k = 0; k < 3; k++)
                if ($urandom_range(0, 1)) c[k] = -c[k];
        end
        return load_row(3'($urandom), c[0], c[1], c[2], 16'($urandom));
    endfunction

    function automatic stim_row_t rand_pair();
        logic [7:0]  sg, kg;
        logic [24:0] elo, ehi;
        if ($urandom_range(0, 6) == 0) begin
            sg = 8'($urandom_range(1, 255));
            kg = 8'($urandom_range(0, sg - 1));
        end else begin
            sg = 8'($urandom_range(0, 255));
            kg = $urandom_range(0, 4) == 0 ? sg : 8'($urandom_range(sg, 255));
        end
        if ($urandom_range(0, 1)) begin
            elo = 25'($urandom);
            ehi = 25'($urandom);
        end else begin
            elo = 25'($urandom_range(0, 2000000));
            ehi = elo + 25'($urandom_range(0, 2000000));
        end
        return pair_row(elo, ehi, $urandom, sg, kg, 1'b0);
    endfunction

    // result side: random stalls
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(negedge aclk);
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                hold = pick_gap();
            end
        end
    end

    // compare each accepted result word with the oldest expectation
    always @(posedge aclk) begin
        kernel_word_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (kernel_expect_q.size() == 0) begin
                $display("%0t: unexpected word kernel_value=%h", $time, m_tdata[31:0]);
                errors++;
            end else begin
                e = kernel_expect_q.pop_front();
                if (m_tdata[31:0] !== e.kernel) begin
                    $display("%0t: kernel_value exp %h got %h", $time, e.kernel,
                             m_tdata[31:0]);
                    errors++;
                end
                if (m_tdata[34:32] !== e.src_ang) begin
                    $display("%0t: src_angle exp %0d got %0d", $time, e.src_ang,
                             m_tdata[34:32]);
                    errors++;
                end
                if (m_tdata[37:35] !== e.snk_ang) begin
                    $display("%0t: sink_angle exp %0d got %0d", $time, e.snk_ang,
                             m_tdata[37:35]);
                    errors++;
                end
                if (m_tdata[54:38] !== e.cosine) begin
                    $display("%0t: cosine_out exp %h got %h", $time, e.cosine,
                             m_tdata[54:38]);
                    errors++;
                end
                if (m_tuser !== e.status) begin
                    $display("%0t: status exp %b got %b", $time, e.status, m_tuser);
                    errors++;
                end
                if (m_tlast !== e.last) begin
                    $display("%0t: last exp %b got %b", $time, e.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    // stimulus
    initial begin
        stim_row_t r;
        int        rn, eff, phase_len;
        bit        done;
        for (int i = 0; i < N_ANG; i++) begin
            dir_wt[i] = '0;
            for (int k = 0; k < 3; k++) dir_cos[i][k] = '0;
        end

        // whole table loaded first, extremes of every field
        directed_rows.push_back(load_row(3'd0, 16'h7FFF, 16'h0000, 16'h0000, 16'd16384));
        directed_rows.push_back(load_row(3'd1, 16'h0000, 16'h7FFF, 16'h0000, 16'hFFFF));
        directed_rows.push_back(load_row(3'd2, 16'h8000, 16'h0000, 16'h0000, 16'd0));
        directed_rows.push_back(load_row(3'd3, 16'h0000, 16'h0000, 16'h7FFF, 16'd1));
        // not a unit vector: cosine above one
        directed_rows.push_back(load_row(3'd4, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'd8192));
        directed_rows.push_back(load_row(3'd5, 16'h8000, 16'h8000, 16'h8000, 16'd4000));
        directed_rows.push_back(load_row(3'd6, 16'd23170, 16'd23170, 16'd0, 16'd12000));
        directed_rows.push_back(load_row(3'd7, 16'd0, -16'sd23170, 16'd23170, 16'd30000));
        directed_rows.push_back(pair_row(25'd0, 25'd0, 32'h0001_0000, 8'd0, 8'd0, 1'b0));
        directed_rows.push_back(pair_row(25'h1FF_FFFF, 25'h1FF_FFFF, 32'hFFFF_FFFF,
                                         8'd10, 8'd255, 1'b0));
        // upscatter: no words
        directed_rows.push_back(pair_row(25'd1000, 25'd2000, 32'h0002_0000,
                                         8'd255, 8'd0, 1'b0));
        directed_rows.push_back(cfg_row(4'd1));
        directed_rows.push_back(pair_row(25'd1000, 25'd2000, 32'h0003_8000, 8'd5, 8'd5, 1'b0));
        // single angle with zero weight: zero sum
        directed_rows.push_back(load_row(3'd0, 16'h7FFF, 16'h0000, 16'h0000, 16'd0));
        directed_rows.push_back(pair_row(25'd500000, 25'd600000, 32'h0001_0000,
                                         8'd1, 8'd2, 1'b1));
        // count of zero acts as one
        directed_rows.push_back(cfg_row(4'd0));
        directed_rows.push_back(pair_row(25'd5, 25'd7, 32'hFFFF_FFFF, 8'd0, 8'd255, 1'b1));
        // count above range acts as full table
        directed_rows.push_back(cfg_row(4'd15));
        directed_rows.push_back(pair_row(25'h1FF_FFFF, 25'h1FF_FFFF, 32'hFFFF_FFFF,
                                         8'd3, 8'd7, 1'b0));
        directed_rows.push_back(cfg_row(4'd2));
        directed_rows.push_back(pair_row(25'd80000, 25'd120000, 32'h0000_0001,
                                         8'd4, 8'd9, 1'b0));

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) write_count(directed_rows[i].cnt);
            else send_word(directed_rows[i]);
        end

        // random phases, each under its own angle count
        done = 1'b0;
        while (words_sent < RANDOM_WORDS + directed_rows.size()) begin
            rn = $urandom_range(0, 19);
            if (rn < 12)      eff = $urandom_range(1, 3);
            else if (rn < 16) eff = $urandom_range(4, 5);
            else if (rn < 18) eff = $urandom_range(6, 8);
            else if (rn == 18) eff = 0;
            else              eff = $urandom_range(9, 15);
            write_count(4'(eff));
            no_idle   = ($urandom_range(0, 3) == 0);
            phase_len = (eff >= 6) ? 6 : 16;
            for (int j = 0; j < phase_len; j++) begin
                r = ($urandom_range(0, 9) < 3) ? rand_load() : rand_pair();
                send_word(r);
            end
        end
        no_idle = 1'b0;
        @(negedge aclk);
        s_tvalid <= 1'b0;

        while (kernel_expect_q.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
